// ----- design/tahc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the timestamp autocorrelation histogram.
package tahc_pkg;

    localparam int BINS_DEFAULT  = 1024;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [31:0] TAU_MIN_RESET   = 32'hFFFF_FE00;
    localparam logic [15:0] BIN_WIDTH_RESET = 16'd1;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

    // Differences at or beyond 2^FAR_BITS ticks never land in any bin.
    localparam int FAR_BITS = 40;
    // Signed width that holds a delay, tau_min and the bin span together.
    localparam int DELAY_W  = 43;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic REG_TAU_MIN   = 1'b0;
    localparam logic REG_BIN_WIDTH = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] stamp;
        logic [9:0]  bin_index;
    } tahc_in_t;

    typedef struct packed {
        logic [31:0] bin_count;
        logic        window_overflow;
        logic        count_saturated;
    } tahc_out_t;

endpackage

// ----- design/tahc_cell.sv -----
`timescale 1ns / 1ps
// One cell of the stamp chain: holds a stamp and its distance to the probe stamp.
module tahc_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [63:0]                    stamp_in,
    input  logic [63:0]                    probe,
    output logic [63:0]                    stamp_out,
    output logic [tahc_pkg::FAR_BITS-1:0]  diff_out,
    output logic                           near_out
);
    import tahc_pkg::*;

    logic [63:0]         stamp_reg;
    logic [FAR_BITS-1:0] diff_reg;
    logic                near_reg;
    logic [63:0]         abs_diff;

    // Distance is symmetric, so stamps out of order pair the same way.
    assign abs_diff = (probe >= stamp_in) ? (probe - stamp_in) : (stamp_in - probe);

    always_ff @(posedge aclk) begin
        if (en) begin
            stamp_reg <= stamp_in;
            diff_reg  <= abs_diff[FAR_BITS-1:0];
            near_reg  <= (abs_diff[63:FAR_BITS] == '0);
        end
    end

    assign stamp_out = stamp_reg;
    assign diff_out  = diff_reg;
    assign near_out  = near_reg;

endmodule

// ----- design/tahc_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the bin index.
module tahc_div #(
    parameter int QW = 10
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [QW+15:0] dividend,
    input  logic [15:0]    divisor,
    output logic           done,
    output logic [QW-1:0]  quotient
);
    import tahc_pkg::*;

    localparam int NW = QW + 16;
    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dsh_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= NW'(divisor) << (QW - 1);
            q_reg   <= '0;
            cnt_reg <= CW'(QW - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= (q_reg << 1) | QW'(fits);
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- design/timestamp_autocorrelation_histogram_core.sv -----
`timescale 1ns / 1ps
// Top level of the timestamp autocorrelation histogram.
//
// Items arrive on the s_ channel (valid/ready); every accepted transfer gives
// exactly one result transfer on the m_ channel. An event item (kind 0) pairs
// its stamp with each stamp held in the window chain, in both directions, and
// counts every delay that lands in a bin. A clear item (kind 1) zeroes the
// histogram, empties the window and drops both sticky flags. A read item
// (kind 2) returns one bin count.
// A read looks up one bin, a clear writes zero to every bin, and an event
// visits each window cell in turn, trying each stored stamp in both
// directions. The window chain is rotated one cell per step and each
// in-range delay is divided by the bin width one quotient bit per cycle,
// then read-modify-written in the histogram memory.
// One item is worked on at a time; the next one is taken while a finished
// result still sits in the output register.
// Reset starts a clearing pass over the histogram memory, during which
// s_ready stays low; configuration writes are taken throughout.
// When the receiver stalls, the result register holds, and a finished item
// waits in its last step until the register is free.
module timestamp_autocorrelation_histogram_core #(
    parameter int BINS         = tahc_pkg::BINS_DEFAULT,
    parameter int WINDOW_DEPTH = tahc_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tahc_pkg::tahc_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output tahc_pkg::tahc_out_t m_payload,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import tahc_pkg::*;

    localparam int QW = $clog2(BINS);
    localparam int NW = QW + 16;
    localparam int RW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int IW = ((QW > 10) ? QW : 10) + 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ROT  = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_PUSH = 4'd6;
    localparam logic [3:0] S_BIN  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    // Configuration registers.
    logic [31:0] tau_min_reg;
    logic [15:0] bin_width_reg;
    logic [15:0] width_eff;
    logic [NW-1:0] span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_min_reg   <= TAU_MIN_RESET;
            bin_width_reg <= BIN_WIDTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TAU_MIN:   tau_min_reg   <= cfg_wdata;
                REG_BIN_WIDTH: bin_width_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // A zero width counts as one tick per bin.
    assign width_eff = (bin_width_reg == '0) ? 16'd1 : bin_width_reg;

    // The span of all bins follows the registers in the next cycle; nothing
    // reads it in the cycle after an item is taken.
    always_ff @(posedge aclk) begin
        span_reg <= NW'(BINS) * NW'(width_eff);
    end

    // Control state.
    logic [3:0]    state_reg;
    logic [RW-1:0] rot_reg;
    logic [FW-1:0] fill_reg;
    logic          neg_reg;
    logic [63:0]   probe_reg;
    logic          bin_ok_reg;
    logic          clr_report_reg;
    logic [QW-1:0] clr_addr_reg;
    logic [QW-1:0] bin_addr_reg;
    logic [31:0]   count_reg;
    logic          ovf_reg;
    logic          sat_reg;
    logic          m_valid_reg;
    tahc_out_t     m_payload_reg;

    // Window chain: cell 0 takes the newest stamp, the last cell holds the
    // oldest. A rotation moves every cell one step and wraps the tail.
    logic [63:0]         cell_stamp [WINDOW_DEPTH];
    logic [FAR_BITS-1:0] cell_diff  [WINDOW_DEPTH];
    logic                cell_near  [WINDOW_DEPTH];
    logic                chain_en;
    logic                chain_push;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
            logic [63:0] cell_in;
            if (gi == 0) begin : g_head
                assign cell_in = chain_push ? probe_reg : cell_stamp[WINDOW_DEPTH-1];
            end else begin : g_body
                assign cell_in = cell_stamp[gi-1];
            end
            tahc_cell u_cell (
                .aclk      (aclk),
                .en        (chain_en),
                .stamp_in  (cell_in),
                .probe     (probe_reg),
                .stamp_out (cell_stamp[gi]),
                .diff_out  (cell_diff[gi]),
                .near_out  (cell_near[gi])
            );
        end
    endgenerate

    // Delay evaluation on the tail cell.
    logic                tail_live;
    logic [DELAY_W-1:0]  tail_d;
    logic [DELAY_W-1:0]  tau_ext;
    logic [DELAY_W-1:0]  span_ext;
    logic [DELAY_W-1:0]  delay;
    logic [DELAY_W-1:0]  offset;
    logic [DELAY_W-1:0]  upper;
    logic                in_range;
    logic                pair_ok;
    logic                ovf_hit;

    // With rot_reg at r the tail holds the entry that sat at cell D-2-r, which
    // is filled when r + fill reaches D-1. On the last step the tail is back at
    // cell D-1, which is only filled in a full window.
    assign tail_live = (fill_reg == FW'(WINDOW_DEPTH))
                       || ((rot_reg != RW'(WINDOW_DEPTH - 1))
                           && (((FW+1)'(rot_reg) + (FW+1)'(fill_reg))
                               >= (FW+1)'(WINDOW_DEPTH - 1)));
    assign tail_d    = DELAY_W'(cell_diff[WINDOW_DEPTH-1]);
    assign tau_ext   = DELAY_W'($signed(tau_min_reg));
    assign span_ext  = DELAY_W'(span_reg);
    assign delay     = neg_reg ? (DELAY_W'(0) - tail_d) : tail_d;
    assign offset    = delay - tau_ext;
    assign in_range  = !offset[DELAY_W-1] && (offset < span_ext);
    assign pair_ok   = tail_live && cell_near[WINDOW_DEPTH-1];
    assign upper     = tau_ext + span_ext;
    assign ovf_hit   = cell_near[WINDOW_DEPTH-1]
                       && (($signed(tail_d) < $signed(upper))
                           || ($signed(DELAY_W'(0) - tail_d) >= $signed(tau_ext)));

    // Bin index divider.
    logic          div_start;
    logic          div_done;
    logic [QW-1:0] div_q;

    assign div_start = (state_reg == S_EVAL) && pair_ok && in_range;

    tahc_div #(.QW(QW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (offset[NW-1:0]),
        .divisor  (width_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    // Histogram memory, one read and one write port, registered read data.
    logic [31:0]   hist_mem [BINS];
    logic          mem_re;
    logic [QW-1:0] mem_raddr;
    logic [31:0]   mem_rdata_reg;
    logic          mem_we;
    logic [QW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [IW-1:0] bi_wide;

    assign bi_wide = IW'(s_payload.bin_index);

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = div_q;
        mem_we    = 1'b0;
        mem_waddr = bin_addr_reg;
        mem_wdata = mem_rdata_reg + 32'd1;
        if (state_reg == S_IDLE && s_valid && s_payload.kind == KIND_READ) begin
            mem_re    = 1'b1;
            mem_raddr = bi_wide[QW-1:0];
        end else if (state_reg == S_DIV && div_done) begin
            mem_re = 1'b1;
        end
        if (state_reg == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (state_reg == S_RD && mem_rdata_reg != COUNT_MAX) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= hist_mem[mem_raddr];
        end
    end

    assign chain_en   = (state_reg == S_ROT) || (state_reg == S_PUSH);
    assign chain_push = (state_reg == S_PUSH);
    assign s_ready    = (state_reg == S_IDLE);

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            fill_reg       <= '0;
            rot_reg        <= '0;
            neg_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            sat_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // In the last step a free register is refilled below instead.
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == QW'(BINS - 1)) begin
                        state_reg <= clr_report_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        count_reg <= '0;
                        case (s_payload.kind)
                            KIND_EVENT: begin
                                probe_reg <= s_payload.stamp;
                                rot_reg   <= '0;
                                neg_reg   <= 1'b0;
                                state_reg <= S_ROT;
                            end
                            KIND_CLEAR: begin
                                fill_reg       <= '0;
                                ovf_reg        <= 1'b0;
                                sat_reg        <= 1'b0;
                                clr_addr_reg   <= '0;
                                clr_report_reg <= 1'b1;
                                state_reg      <= S_CLR;
                            end
                            KIND_READ: begin
                                bin_ok_reg <= (bi_wide < IW'(BINS));
                                state_reg  <= S_BIN;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ROT: begin
                    state_reg <= S_EVAL;
                end
                S_EVAL, S_RD: begin
                    if (state_reg == S_RD && mem_rdata_reg == COUNT_MAX - 32'd1) begin
                        sat_reg <= 1'b1;
                    end
                    if (state_reg == S_EVAL && pair_ok && in_range) begin
                        state_reg <= S_DIV;
                    end else if (!neg_reg && pair_ok) begin
                        neg_reg   <= 1'b1;
                        state_reg <= S_EVAL;
                    end else begin
                        neg_reg <= 1'b0;
                        if (rot_reg == RW'(WINDOW_DEPTH - 1)) begin
                            state_reg <= S_PUSH;
                        end else begin
                            rot_reg   <= rot_reg + 1'b1;
                            state_reg <= S_ROT;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        bin_addr_reg <= div_q;
                        state_reg    <= S_RD;
                    end
                end
                S_PUSH: begin
                    // After a full turn the tail holds the oldest stamp again.
                    if (fill_reg == FW'(WINDOW_DEPTH)) begin
                        if (ovf_hit) begin
                            ovf_reg <= 1'b1;
                        end
                    end else begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_BIN: begin
                    count_reg <= bin_ok_reg ? mem_rdata_reg : '0;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg                   <= 1'b1;
                        m_payload_reg.bin_count       <= count_reg;
                        m_payload_reg.window_overflow <= ovf_reg;
                        m_payload_reg.count_saturated <= sat_reg;
                        clr_report_reg                <= 1'b0;
                        state_reg                     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// ----- design/tahc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the histogram core, bound to the top level.
module tahc_port_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tahc_pkg::tahc_out_t m_payload
);
    import tahc_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Reset starts the histogram clearing pass, which takes no items.
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("item taken right after reset");

    // Items are worked on one at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

endmodule

bind timestamp_autocorrelation_histogram_core tahc_port_checker u_tahc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

// ----- test/tahc_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the histogram core: watches both channels, predicts and compares.
module tahc_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tahc_pkg::tahc_in_t  s_payload,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tahc_pkg::tahc_out_t m_payload,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata,
    output int                  errors,
    output int                  pending
);
    import tahc_pkg::*;

    localparam int NBINS  = 1024;
    localparam int NDEPTH = 16;

    logic [63:0] ring [NDEPTH];
    int unsigned ring_fill;
    int unsigned ring_head;
    logic [31:0] hist [NBINS];
    logic        flag_ovf;
    logic        flag_sat;
    longint      tau;
    logic [15:0] width;
    tahc_out_t   expected_q [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic longint span_w();
        return (width == 16'd0) ? 64'sd1 : longint'({48'd0, width});
    endfunction

    task automatic count_delay(input longint delay);
        longint off;
        longint w;
        int b;
        w   = span_w();
        off = delay - tau;
        if (off < 0 || off >= NBINS * w) return;
        b = int'(off / w);
        if (hist[b] != COUNT_MAX) begin
            hist[b] = hist[b] + 32'd1;
            if (hist[b] == COUNT_MAX) flag_sat = 1'b1;
        end
    endtask

    task automatic predict_result(input tahc_in_t it, output tahc_out_t r);
        logic [63:0] d;
        longint sd;
        int unsigned idx;
        r.bin_count = '0;
        if (it.kind == KIND_EVENT) begin
            for (int k = 0; k < ring_fill; k++) begin
                idx = (ring_head + k) % NDEPTH;
                d = (it.stamp >= ring[idx]) ? it.stamp - ring[idx] : ring[idx] - it.stamp;
                if (d < (64'd1 << 40)) begin
                    count_delay(longint'(d));
                    count_delay(-longint'(d));
                end
            end
            if (ring_fill < NDEPTH) begin
                ring[(ring_head + ring_fill) % NDEPTH] = it.stamp;
                ring_fill++;
            end else begin
                d = (it.stamp >= ring[ring_head]) ? it.stamp - ring[ring_head]
                                                  : ring[ring_head] - it.stamp;
                if (d < (64'd1 << 40)) begin
                    sd = longint'(d);
                    if (sd < tau + NBINS * span_w() || -sd >= tau) flag_ovf = 1'b1;
                end
                ring[ring_head] = it.stamp;
                ring_head = (ring_head + 1) % NDEPTH;
            end
        end else if (it.kind == KIND_CLEAR) begin
            foreach (hist[i]) hist[i] = '0;
            ring_fill = 0;
            ring_head = 0;
            flag_ovf  = 1'b0;
            flag_sat  = 1'b0;
        end else if (it.kind == KIND_READ) begin
            r.bin_count = hist[it.bin_index];
        end
        r.window_overflow = flag_ovf;
        r.count_saturated = flag_sat;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t checker: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        tahc_out_t r;
        tahc_out_t e;
        if (!aresetn) begin
            foreach (hist[i]) hist[i] = '0;
            ring_fill = 0;
            ring_head = 0;
            flag_ovf  = 1'b0;
            flag_sat  = 1'b0;
            tau       = -512;
            width     = BIN_WIDTH_RESET;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TAU_MIN) tau = longint'(signed'(cfg_wdata));
                else width = cfg_wdata[15:0];
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, count", m_payload.bin_count, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (m_payload.bin_count != e.bin_count)
                        report_mismatch("bin_count", m_payload.bin_count, e.bin_count);
                    if (m_payload.window_overflow != e.window_overflow)
                        report_mismatch("window_overflow", m_payload.window_overflow,
                                        e.window_overflow);
                    if (m_payload.count_saturated != e.count_saturated)
                        report_mismatch("count_saturated", m_payload.count_saturated,
                                        e.count_saturated);
                end
            end
            if (s_valid && s_ready) begin
                predict_result(s_payload, r);
                expected_q.push_back(r);
            end
        end
        pending = expected_q.size();
    end
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Top of the histogram core testbench: clock, reset, stimulus and verdict.
module tb;
    import tahc_pkg::*;

    // The slowest items are a clear and an event whose 32 delays all land
    // in range; the limit leaves ample room for those plus the long receiver
    // hold-off.
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int ITEMS_PER_PHASE = 225;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tahc_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tahc_out_t m_payload;
    logic      cfg_we = 1'b0;
    logic      cfg_index = REG_TAU_MIN;
    logic [31:0] cfg_wdata = '0;

    int errors;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    longint tau_now = -512;
    int width_now = 1;
    logic [63:0] stamp_now = 64'd1000;

    always #5 aclk = ~aclk;

    timestamp_autocorrelation_histogram_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    tahc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // Receiver side. A hold-off request makes this process keep ready low for
    // a long stretch that it counts itself; otherwise ready is randomized.
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // The watchdog counts cycles in which no transfer happens on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired with %0d results outstanding", pending);
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one item and returns once its transfer has happened. Valid is only
    // lowered when a random gap is taken, so back-to-back items keep it high.
    task automatic send_item(input logic [1:0] kind, input logic [63:0] stamp,
                             input logic [9:0] idx);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{kind: kind, stamp: stamp, bin_index: idx};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Waits for every expected result, lets the core settle, then writes both
    // registers. Writes are only made while the core is idle.
    task automatic set_config(input longint tau_val, input int width_val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TAU_MIN;
        cfg_wdata <= tau_val[31:0];
        @(posedge aclk);
        cfg_index <= REG_BIN_WIDTH;
        cfg_wdata <= {16'($urandom), width_val[15:0]};
        @(posedge aclk);
        cfg_we <= 1'b0;
        tau_now   = tau_val;
        width_now = (width_val == 0) ? 1 : width_val;
    endtask

    // Picks a random item: mostly events with a slowly rising stamp, so pairs
    // land in bins, plus reads aimed at the zero-delay region, clears, and noise.
    task automatic random_item();
        int sel;
        int zero_bin;
        logic [9:0] idx;
        sel = $urandom_range(99);
        if (sel < 62) begin
            case ($urandom_range(19))
                0:       stamp_now = stamp_now + (64'd1 << 41);
                1:       stamp_now = {$urandom, $urandom};
                2, 3:    stamp_now = (stamp_now > 300) ? stamp_now - $urandom_range(300)
                                                       : stamp_now;
                default: stamp_now = stamp_now + $urandom_range(width_now > 8 ? 3000 : 400);
            endcase
            send_item(KIND_EVENT, stamp_now, 10'($urandom));
        end else if (sel < 95) begin
            zero_bin = 512;
            if (tau_now <= 0 && -tau_now < 1024 * longint'(width_now))
                zero_bin = int'(-tau_now / width_now);
            if ($urandom_range(1)) idx = 10'($urandom);
            else idx = 10'(zero_bin + $urandom_range(80) - 40);
            send_item(KIND_READ, {$urandom, $urandom}, idx);
        end else if (sel < 97) begin
            send_item(KIND_CLEAR, {$urandom, $urandom}, 10'($urandom));
        end else begin
            send_item(2'd3, {$urandom, $urandom}, 10'($urandom));
        end
    endtask

    initial begin
        longint taus [6];
        int widths [6];
        int stalls [4];
        int idles [4];
        taus   = '{-512, -64'sd2147483648, 2147483647, 0, -30000, -100};
        widths = '{1, 65535, 7, 0, 40, 3};
        idles  = '{0, 87, 0, 38};
        stalls = '{0, 0, 87, 38};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset settings: equal stamps, out-of-order
        // stamps, a full ring that drops its oldest stamp, far delays, the
        // largest stamp, reads at both ends of the histogram, the unused kind
        // and a clear.
        send_item(KIND_EVENT, 64'd1000, 10'd0);
        send_item(KIND_EVENT, 64'd1000, 10'd1023);
        send_item(KIND_EVENT, 64'd1005, 10'd0);
        send_item(KIND_EVENT, 64'd1003, 10'd0);
        send_item(KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 10'd512);
        send_item(KIND_READ, 64'd0, 10'd517);
        send_item(KIND_READ, 64'd0, 10'd507);
        send_item(KIND_READ, 64'd0, 10'd0);
        send_item(KIND_READ, 64'd0, 10'd1023);
        send_item(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
        for (int i = 0; i < 14; i++) send_item(KIND_EVENT, 64'd1010 + 64'(i), 10'd0);
        send_item(KIND_READ, 64'd0, 10'd513);
        send_item(KIND_EVENT, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
        send_item(KIND_EVENT, 64'd0, 10'd0);
        send_item(KIND_CLEAR, 64'd0, 10'd0);
        send_item(KIND_READ, 64'd0, 10'd512);

        // Random phases, each under its own register settings, cycling through four idle mixes.
        for (int p = 0; p < 6; p++) begin
            set_config(taus[p], widths[p]);
            idle_pct  = idles[p % 4];
            stall_pct = stalls[p % 4];
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Long receiver hold-off while the sender keeps offering items.
                if (p == 1 && i == 60) hold_requests++;
                // Sender pauses until every expected result has come back.
                if (p == 4 && i == 100) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
                random_item();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (1100) @(posedge aclk);

        $display("tb: %0d items over 6 register settings and 4 idle mixes", items_sent);
        $display("tb: %0d mismatches, %0d results outstanding", errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
